### hdl/frnpl_pkg.sv
// shared types and constants of the fixed-radius nearest point lookup
package frnpl_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [14:0] RADIUS_RESET = 15'd256;

    typedef logic [14:0] cfg_word_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } pos_t;

    typedef struct packed {
        logic        [15:0] chem;
        logic        [15:0] speed;
        logic signed [15:0] dir;
    } odor_t;

    typedef struct packed {
        pos_t  pos;
        odor_t odor;
    } point_t;

    typedef struct packed {
        logic        [1:0]  operation;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic        [15:0] chemical_level;
        logic        [15:0] wind_speed;
        logic signed [15:0] wind_direction;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic        [15:0] chemical_out;
        logic        [15:0] wind_speed_out;
        logic signed [15:0] wind_direction_out;
        logic               overflow_seen;
    } out_item_t;

endpackage

### hdl/frnpl_stream_if.sv
// valid/ready channel carrying one item of a given payload type
interface frnpl_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/frnpl_point_mem.sv
// point frame memory: one write port, one registered read port
module frnpl_point_mem #(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  frnpl_pkg::point_t    wr_data,
    input  logic [AW-1:0]        rd_addr,
    output frnpl_pkg::point_t    rd_data_reg
);
    frnpl_pkg::point_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end
endmodule

### hdl/frnpl_sq_unit.sv
// shared unit: registered square of the difference of two signed words
module frnpl_sq_unit (
    input  logic               clk,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    output logic        [31:0] sq_reg
);
    logic signed [16:0] diff;
    logic        [16:0] neg_diff;
    logic        [15:0] mag;
    logic        [31:0] sq_next;

    assign diff     = {a[15], a} - {b[15], b};
    assign neg_diff = 17'(-diff);
    assign mag      = diff[16] ? neg_diff[15:0] : diff[15:0];
    assign sq_next  = 32'(mag) * 32'(mag);

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end
endmodule

### hdl/fixed_radius_nearest_point_lookup.sv
// top level: frame of sample points with fixed-radius nearest point query
// Clear and append items are handled as they are accepted; an append to a full frame is
// dropped and sets overflow_seen until the next clear. A query squares the
// radius and then scans the stored points in load order, one axis at a time,
// because one squaring multiplier handles one axis per cycle. The block
// takes no item while a query runs. A finished result waits in an output
// register, so the next item may be taken before the result is read. The
// radius register is written through the cfg channel, which is always ready.
module fixed_radius_nearest_point_lookup #(
    parameter int MAX_POINTS = 1024
) (
    input logic            clk,
    input logic            rst_n,
    frnpl_stream_if.sink   item_in,
    frnpl_stream_if.source result_out,
    frnpl_stream_if.sink   cfg
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_PUT  = 3'd4;

    localparam logic [1:0] PH_X = 2'd0;
    localparam logic [1:0] PH_Y = 2'd1;
    localparam logic [1:0] PH_Z = 2'd2;

    logic [2:0]           state_reg;
    logic [1:0]           ph_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        idx_inc;
    logic [CW-1:0]        count_reg;
    logic                 dropped_reg;
    frnpl_pkg::cfg_word_t radius_reg;
    logic                 init_reg;
    logic                 pend_reg;
    logic                 found_reg;
    logic                 out_valid_reg;

    frnpl_pkg::pos_t      q_reg;
    logic [32:0]          acc_reg;
    logic [33:0]          best_reg;
    logic [33:0]          dist_sum;
    frnpl_pkg::odor_t     cand_reg;
    frnpl_pkg::odor_t     hit_reg;
    frnpl_pkg::out_item_t out_data_reg;

    logic                 in_acc;
    logic                 full;
    logic                 wr_en;
    frnpl_pkg::point_t    wr_data;
    logic [AW-1:0]        rd_addr;
    frnpl_pkg::point_t    rd_data;
    logic signed [15:0]   op_a;
    logic signed [15:0]   op_b;
    logic [31:0]          sq;
    logic                 closer;
    logic                 out_free;

    assign item_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign in_acc        = item_in.valid && item_in.ready;
    assign full          = (count_reg == CW'(MAX_POINTS));
    assign idx_inc       = idx_reg + CW'(1);

    assign wr_en = in_acc && (item_in.data.operation == frnpl_pkg::OP_APPEND) && !full;
    assign wr_data.pos.x      = item_in.data.pos_x;
    assign wr_data.pos.y      = item_in.data.pos_y;
    assign wr_data.pos.z      = item_in.data.pos_z;
    assign wr_data.odor.chem  = item_in.data.chemical_level;
    assign wr_data.odor.speed = item_in.data.wind_speed;
    assign wr_data.odor.dir   = item_in.data.wind_direction;

    // the next point is fetched during the z step
    assign rd_addr = ((state_reg == ST_SCAN) && (ph_reg == PH_Z)) ? idx_inc[AW-1:0]
                                                                   : idx_reg[AW-1:0];

    frnpl_point_mem #(
        .DEPTH(MAX_POINTS)
    ) u_mem (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (count_reg[AW-1:0]),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    always_comb
    begin
        op_a = q_reg.x;
        op_b = rd_data.pos.x;
        if (state_reg == ST_LOAD)
        begin
            op_a = {1'b0, radius_reg};
            op_b = 16'sd0;
        end
        else
        begin
            case (ph_reg)
                PH_Y:
                begin
                    op_a = q_reg.y;
                    op_b = rd_data.pos.y;
                end
                PH_Z:
                begin
                    op_a = q_reg.z;
                    op_b = rd_data.pos.z;
                end
                default:
                begin
                    op_a = q_reg.x;
                    op_b = rd_data.pos.x;
                end
            endcase
        end
    end

    frnpl_sq_unit u_sq (
        .clk    (clk),
        .a      (op_a),
        .b      (op_b),
        .sq_reg (sq)
    );

    assign dist_sum = {1'b0, acc_reg} + {2'b00, sq};
    assign closer   = pend_reg && (dist_sum < best_reg);
    assign out_free = !out_valid_reg || result_out.ready;

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= frnpl_pkg::RADIUS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            radius_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= PH_X;
            idx_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            init_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (item_in.data.operation)
                            frnpl_pkg::OP_CLEAR:
                            begin
                                count_reg   <= '0;
                                dropped_reg <= 1'b0;
                            end
                            frnpl_pkg::OP_APPEND:
                            begin
                                if (full)
                                begin
                                    dropped_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            frnpl_pkg::OP_QUERY:
                            begin
                                idx_reg   <= '0;
                                found_reg <= 1'b0;
                                pend_reg  <= 1'b0;
                                state_reg <= ST_LOAD;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    init_reg  <= 1'b1;
                    ph_reg    <= PH_X;
                    state_reg <= (count_reg == '0) ? ST_FIN : ST_SCAN;
                end
                ST_SCAN:
                begin
                    unique case (ph_reg)
                        PH_X:
                        begin
                            init_reg <= 1'b0;
                            pend_reg <= 1'b0;
                            if (closer)
                            begin
                                found_reg <= 1'b1;
                            end
                            ph_reg <= PH_Y;
                        end
                        PH_Y:
                        begin
                            ph_reg <= PH_Z;
                        end
                        PH_Z:
                        begin
                            pend_reg <= 1'b1;
                            idx_reg  <= idx_inc;
                            ph_reg   <= PH_X;
                            if (idx_inc == count_reg)
                            begin
                                state_reg <= ST_FIN;
                            end
                        end
                        default:
                        begin
                            ph_reg <= PH_X;
                        end
                    endcase
                end
                ST_FIN:
                begin
                    pend_reg <= 1'b0;
                    if (closer)
                    begin
                        found_reg <= 1'b1;
                    end
                    state_reg <= ST_PUT;
                end
                ST_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (item_in.data.operation == frnpl_pkg::OP_QUERY))
        begin
            q_reg.x <= item_in.data.pos_x;
            q_reg.y <= item_in.data.pos_y;
            q_reg.z <= item_in.data.pos_z;
            hit_reg <= '0;
        end
        if ((state_reg == ST_SCAN) && (ph_reg == PH_X) && init_reg)
        begin
            best_reg <= {2'b00, sq};
        end
        if ((state_reg == ST_SCAN) && (ph_reg == PH_Y))
        begin
            acc_reg <= {1'b0, sq};
        end
        if ((state_reg == ST_SCAN) && (ph_reg == PH_Z))
        begin
            acc_reg  <= acc_reg + {1'b0, sq};
            cand_reg <= rd_data.odor;
        end
        if (((state_reg == ST_SCAN) && (ph_reg == PH_X)) || (state_reg == ST_FIN))
        begin
            if (closer)
            begin
                best_reg <= dist_sum;
                hit_reg  <= cand_reg;
            end
        end
        if ((state_reg == ST_PUT) && out_free)
        begin
            out_data_reg.found              <= found_reg;
            out_data_reg.chemical_out       <= hit_reg.chem;
            out_data_reg.wind_speed_out     <= hit_reg.speed;
            out_data_reg.wind_direction_out <= hit_reg.dir;
            out_data_reg.overflow_seen      <= dropped_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg < count_reg))
        else $error("scan index past stored points");

    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (item_in.data.operation == frnpl_pkg::OP_QUERY)) |=> (state_reg == ST_LOAD))
        else $error("query item did not start a scan");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dropped_reg) |-> full)
        else $error("drop flagged while frame not full");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |->
        ((out_data_reg.chemical_out == 16'd0) && (out_data_reg.wind_speed_out == 16'd0)
         && (out_data_reg.wind_direction_out == 16'sd0)))
        else $error("odor data on a miss is not zero");
endmodule

### tb/tb.sv
// testbench for the fixed-radius nearest point lookup: directed and random frames
module tb;

    localparam int MAX_POINTS = 1024;
    localparam int RANDOM_ITEMS = 580;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    frnpl_stream_if #(.T(frnpl_pkg::in_item_t))  item_ch ();
    frnpl_stream_if #(.T(frnpl_pkg::out_item_t)) result_ch ();
    frnpl_stream_if #(.T(frnpl_pkg::cfg_word_t)) cfg_ch ();

    fixed_radius_nearest_point_lookup #(.MAX_POINTS(MAX_POINTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_in(item_ch),
        .result_out(result_ch),
        .cfg(cfg_ch)
    );

    frnpl_pkg::pos_t      frame_pos [MAX_POINTS];
    frnpl_pkg::odor_t     frame_odor [MAX_POINTS];
    int                   frame_count = 0;
    bit                   frame_dropped = 1'b0;
    frnpl_pkg::cfg_word_t radius_q88 = frnpl_pkg::RADIUS_RESET;

    frnpl_pkg::out_item_t pending_lookups[$];
    frnpl_pkg::out_item_t want;
    int        mismatches = 0;
    int        cycles = 0;
    int        burst_left = 0;
    int        stall_mode = 0;
    int        mode_left = 0;

    always #4 clk = ~clk;

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            0: result_ch.ready <= 1'b1;
            1: result_ch.ready <= ($urandom_range(0, 3) != 0);
            default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic frnpl_pkg::out_item_t nearest_odor(input frnpl_pkg::in_item_t it);
        frnpl_pkg::out_item_t res;
        longint    best;
        longint    dist_sq;
        longint    dx;
        longint    dy;
        longint    dz;
        res = '0;
        best = longint'(radius_q88) * longint'(radius_q88);
        for (int i = 0; i < frame_count; i++)
        begin
            dx = longint'(it.pos_x) - longint'(frame_pos[i].x);
            dy = longint'(it.pos_y) - longint'(frame_pos[i].y);
            dz = longint'(it.pos_z) - longint'(frame_pos[i].z);
            dist_sq = dx * dx + dy * dy + dz * dz;
            if (dist_sq < best)
            begin
                best = dist_sq;
                res.found = 1'b1;
                res.chemical_out = frame_odor[i].chem;
                res.wind_speed_out = frame_odor[i].speed;
                res.wind_direction_out = frame_odor[i].dir;
            end
        end
        res.overflow_seen = frame_dropped;
        return res;
    endfunction

    task automatic apply_to_frame(input frnpl_pkg::in_item_t it);
        case (it.operation)
            frnpl_pkg::OP_CLEAR:
            begin
                frame_count = 0;
                frame_dropped = 1'b0;
            end
            frnpl_pkg::OP_APPEND:
            begin
                if (frame_count >= MAX_POINTS)
                begin
                    frame_dropped = 1'b1;
                end
                else
                begin
                    frame_pos[frame_count].x = it.pos_x;
                    frame_pos[frame_count].y = it.pos_y;
                    frame_pos[frame_count].z = it.pos_z;
                    frame_odor[frame_count].chem = it.chemical_level;
                    frame_odor[frame_count].speed = it.wind_speed;
                    frame_odor[frame_count].dir = it.wind_direction;
                    frame_count++;
                end
            end
            frnpl_pkg::OP_QUERY:
            begin
                pending_lookups.push_back(nearest_odor(it));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic signed [16:0] exp_val,
                               input logic signed [16:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("lookup result with no query waiting");
                mismatches++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                check_field("found", want.found, result_ch.data.found);
                check_field("chemical_out", want.chemical_out, result_ch.data.chemical_out);
                check_field("wind_speed_out", want.wind_speed_out,
                            result_ch.data.wind_speed_out);
                check_field("wind_direction_out", want.wind_direction_out,
                            result_ch.data.wind_direction_out);
                check_field("overflow_seen", want.overflow_seen,
                            result_ch.data.overflow_seen);
            end
        end
    end

    task automatic send_item(input frnpl_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        burst_left--;
        apply_to_frame(it);
    endtask

    task automatic send_point(input int x, input int y, input int z,
                              input int chem, input int speed, input int dir);
        frnpl_pkg::in_item_t it;
        it.operation = frnpl_pkg::OP_APPEND;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.pos_z = 16'(z);
        it.chemical_level = 16'(chem);
        it.wind_speed = 16'(speed);
        it.wind_direction = 16'(dir);
        send_item(it);
    endtask

    task automatic send_query(input int x, input int y, input int z);
        frnpl_pkg::in_item_t it;
        it = frnpl_pkg::in_item_t'({$urandom, $urandom, $urandom});
        it.operation = frnpl_pkg::OP_QUERY;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.pos_z = 16'(z);
        send_item(it);
    endtask

    task automatic send_other(input logic [1:0] op);
        frnpl_pkg::in_item_t it;
        it = frnpl_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.operation = op;
        send_item(it);
    endtask

    task automatic wait_frame_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_radius(input frnpl_pkg::cfg_word_t value);
        wait_frame_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        radius_q88 = value;
    endtask

    task automatic test_reset_radius_boundary();
        send_query(0, 0, 0);
        send_point(0, 0, 0, 16'hffff, 16'h0000, 16'h7fff);
        send_query(255, 0, 0);
        send_query(0, 256, 0);
        send_query(0, 0, -255);
    endtask

    task automatic test_field_extremes();
        write_radius(15'h7fff);
        send_other(frnpl_pkg::OP_CLEAR);
        send_point(-32768, -32768, -32768, 16'hffff, 16'hffff, -32768);
        send_point(32767, 32767, 32767, 16'h0000, 16'h0000, 32767);
        send_query(-32768, -32768, -32768);
        send_query(32767, 32767, 32767);
        send_query(32767, -32768, 0);
    endtask

    task automatic test_distance_ties();
        write_radius(frnpl_pkg::RADIUS_RESET);
        send_other(frnpl_pkg::OP_CLEAR);
        send_point(10, 0, 0, 11, 12, 13);
        send_point(-10, 0, 0, 21, 22, -23);
        send_point(10, 0, 0, 31, 32, 33);
        send_query(0, 0, 0);
        send_query(10, 0, 0);
    endtask

    task automatic test_unused_op_and_clear();
        send_other(OP_UNUSED);
        send_query(-10, 0, 0);
        send_other(frnpl_pkg::OP_CLEAR);
        send_query(10, 0, 0);
    endtask

    task automatic test_radius_zero();
        send_point(5, 5, 5, 1, 2, 3);
        write_radius(15'd0);
        send_query(5, 5, 5);
    endtask

    task automatic test_frame_overflow();
        write_radius(15'd2048);
        send_other(frnpl_pkg::OP_CLEAR);
        for (int k = 0; k < MAX_POINTS; k++)
            send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_query(frame_pos[0].x, frame_pos[0].y, frame_pos[0].z);
        send_point(100, 100, 100, 7, 8, 9);
        send_point(100, 100, 100, 7, 8, 9);
        send_query(frame_pos[MAX_POINTS - 1].x, frame_pos[MAX_POINTS - 1].y,
                   frame_pos[MAX_POINTS - 1].z);
        send_query(100, 100, 100);
        send_other(frnpl_pkg::OP_CLEAR);
        send_query(100, 100, 100);
    endtask

    function automatic frnpl_pkg::cfg_word_t pick_radius();
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return 15'h7fff;
            2: return frnpl_pkg::cfg_word_t'($urandom_range(1, 16));
            3: return frnpl_pkg::cfg_word_t'($urandom_range(16, 1024));
            4: return frnpl_pkg::cfg_word_t'($urandom_range(1024, 32767));
            default: return frnpl_pkg::RADIUS_RESET;
        endcase
    endfunction

    function automatic logic signed [15:0] jitter(input logic signed [15:0] c, input int spread);
        int off;
        off = int'($urandom_range(0, 2 * spread)) - spread;
        return 16'(int'(c) + off);
    endfunction

    task automatic test_random_frames();
        int sent;
        int n;
        int pick;
        int spread;
        int idx;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                write_radius(pick_radius());
            cx = 16'($urandom);
            cy = 16'($urandom);
            cz = 16'($urandom);
            spread = (int'(radius_q88) * $urandom_range(1, 4)) / 4 + 1;
            send_other(frnpl_pkg::OP_CLEAR);
            sent++;
            n = $urandom_range(4, 40);
            for (int k = 0; k < n; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8 && frame_count > 0)
                begin
                    idx = $urandom_range(0, frame_count - 1);
                    send_point(frame_pos[idx].x, frame_pos[idx].y, frame_pos[idx].z,
                               $urandom, $urandom, $urandom);
                end
                else if (pick < 50)
                begin
                    send_point(jitter(cx, spread), jitter(cy, spread), jitter(cz, spread),
                               $urandom, $urandom, $urandom);
                end
                else if (pick < 58 && frame_count > 0)
                begin
                    idx = $urandom_range(0, frame_count - 1);
                    send_query(frame_pos[idx].x, frame_pos[idx].y, frame_pos[idx].z);
                end
                else if (pick < 88)
                begin
                    send_query(jitter(cx, spread), jitter(cy, spread), jitter(cz, spread));
                end
                else if (pick < 92)
                begin
                    send_other(OP_UNUSED);
                    sent--;
                end
                else if (pick < 95)
                begin
                    send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
                else if (pick < 99)
                begin
                    send_query($urandom, $urandom, $urandom);
                end
                else
                begin
                    send_other(frnpl_pkg::OP_CLEAR);
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_radius_boundary();
        test_field_extremes();
        test_distance_ties();
        test_unused_op_and_clear();
        test_radius_zero();
        test_frame_overflow();
        test_random_frames();
        wait_frame_idle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
